/* hw/rtl/rabs_pkg.sv */
`timescale 1ns / 1ps
package rabs_pkg;

	localparam int unsigned FRAME_PIXELS = 262144;
	localparam int unsigned POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_LEARN_RATE   = 2'd0,
		REG_FG_THRESHOLD = 2'd1,
		REG_THRESHOLD_EN = 2'd2
	} reg_idx_t;

	localparam logic [15:0] LEARN_RATE_RESET   = 16'd3277;
	localparam logic [7:0]  FG_THRESHOLD_RESET = 8'd15;
	localparam logic        THRESHOLD_EN_RESET = 1'b1;

	localparam logic [7:0] MASK_ON  = 8'hFF;
	localparam logic [7:0] MASK_OFF = 8'h00;
	localparam logic signed [25:0] HALF_Q16 = 26'sd32768;

	typedef struct packed {
		logic [15:0] learn_rate_q16;
		logic [7:0]  fg_threshold;
		logic        threshold_enable;
	} cfg_t;

endpackage

/* hw/rtl/rabs_stream_if.sv */
`timescale 1ns / 1ps
interface rabs_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       end_of_frame;

	modport source (output valid, output pixel_value, output end_of_frame, input ready);
	modport sink (input valid, input pixel_value, input end_of_frame, output ready);
endinterface

interface rabs_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] foreground_value;
	logic [7:0] background_value;

	modport source (output valid, output foreground_value, output background_value,
		input ready);
	modport sink (input valid, input foreground_value, input background_value,
		output ready);
endinterface

/* hw/rtl/running_average_background_subtract.sv */
`timescale 1ns / 1ps
// Running-average background subtraction for an 8-bit grayscale pixel stream.
// Input channel "pixels" carries pixel_value and end_of_frame in raster order;
// output channel "results" carries one word per pixel: foreground_value
// (|pixel - background|, or a 0/255 mask when threshold_enable is set) and
// the updated background_value. Both channels use valid/ready.
// Registers (APB, byte address 4*i): learn_rate_q16, fg_threshold,
// threshold_enable. Write them only while no word is in flight.
// One pixel per clock unless results stall. A pixel passes the input register,
// then the result register, before its result word is valid. One input register
// (background read from the frame store, one port per cycle each way) feeds one
// result register; the blend is a single 17x9 multiply in between. A write and
// a read of the same entry at the same edge are resolved by forwarding.
// Reset clears the handshake state, the frame position and the "first frame
// done" flag; the frame store is not cleared, the first frame is copied in.
// When the receiver stalls, the result register holds, one more pixel is taken
// into the input register, and then pixels.ready drops until results drain.
module running_average_background_subtract (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rabs_pkg::PADDR_W-1:0]      paddr,
	input  logic [rabs_pkg::PDATA_W-1:0]      pwdata,
	output logic [rabs_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	rabs_pix_if.sink                          pixels,
	rabs_res_if.source                        results
);

	rabs_pkg::cfg_t cfg;

	rabs_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [7:0] bg_mem [rabs_pkg::FRAME_PIXELS];

	logic [rabs_pkg::POS_W-1:0] pos_q;
	logic                       bvalid_q;

	logic                       valid_s1;
	logic [7:0]                 pix_s1;
	logic [rabs_pkg::POS_W-1:0] pos_s1;
	logic                       bval_s1;
	logic [7:0]                 bg_rd_s1;
	logic                       fwd_hit_s1;
	logic [7:0]                 fwd_data_s1;

	logic                       valid_s2;
	logic [7:0]                 fg_s2;
	logic [7:0]                 bg_s2;

	logic                       in_acc;
	logic                       s1_fire;
	logic [rabs_pkg::POS_W-1:0] pos_next;

	logic [7:0]                 old_c;
	logic [7:0]                 diff_c;
	logic [7:0]                 fg_c;
	logic signed [8:0]          delta_c;
	logic signed [25:0]         prod_c;
	logic signed [25:0]         rnd_c;
	logic signed [9:0]          step_c;
	logic signed [9:0]          nb_wide_c;
	logic [7:0]                 nb_c;

	assign s1_fire       = valid_s1 && (!valid_s2 || results.ready);
	assign pixels.ready  = !valid_s1 || s1_fire;
	assign in_acc        = pixels.valid && pixels.ready;

	always_comb begin
		if (pixels.end_of_frame || pos_q == rabs_pkg::POS_W'(rabs_pkg::FRAME_PIXELS - 1)) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bvalid_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q <= pos_next;
				if (pixels.end_of_frame) begin
					bvalid_q <= 1'b1;
				end
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			bg_mem[pos_s1] <= nb_c;
		end
		if (in_acc) begin
			bg_rd_s1 <= bg_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= pixels.pixel_value;
			pos_s1      <= pos_q;
			bval_s1     <= bvalid_q;
			fwd_hit_s1  <= s1_fire && (pos_s1 == pos_q);
			fwd_data_s1 <= nb_c;
		end
		if (s1_fire) begin
			fg_s2 <= fg_c;
			bg_s2 <= nb_c;
		end
	end

	always_comb begin
		if (!bval_s1) begin
			old_c = pix_s1;
		end else if (fwd_hit_s1) begin
			old_c = fwd_data_s1;
		end else begin
			old_c = bg_rd_s1;
		end
	end

	// new = old + floor((a*(pix-old) + 2^15) / 2^16)
	assign diff_c    = (pix_s1 > old_c) ? (pix_s1 - old_c) : (old_c - pix_s1);
	assign delta_c   = $signed({1'b0, pix_s1}) - $signed({1'b0, old_c});
	assign prod_c    = $signed({10'd0, cfg.learn_rate_q16}) * 26'(delta_c);
	assign rnd_c     = prod_c + rabs_pkg::HALF_Q16;
	assign step_c    = rnd_c[25:16];
	assign nb_wide_c = $signed({2'b00, old_c}) + step_c;
	assign nb_c      = nb_wide_c[7:0];

	always_comb begin
		if (cfg.threshold_enable) begin
			fg_c = (diff_c > cfg.fg_threshold) ? rabs_pkg::MASK_ON : rabs_pkg::MASK_OFF;
		end else begin
			fg_c = diff_c;
		end
	end

	assign results.valid            = valid_s2;
	assign results.foreground_value = fg_s2;
	assign results.background_value = bg_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1)
		else $error("input register lost a stalled pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pixels.end_of_frame |=> pos_q == '0)
		else $error("frame position not rewound at end of frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !bval_s1 |-> fg_c == rabs_pkg::MASK_OFF && nb_c == pix_s1)
		else $error("first frame not copied into background");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cfg.threshold_enable |->
			fg_c == rabs_pkg::MASK_OFF || fg_c == rabs_pkg::MASK_ON)
		else $error("mask value not binary");

	assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> valid_s1 && valid_s2)
		else $error("input blocked with free pipeline space");

endmodule

/* hw/rtl/rabs_cfg_regs.sv */
`timescale 1ns / 1ps
module rabs_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rabs_pkg::PADDR_W-1:0]      paddr,
	input  logic [rabs_pkg::PDATA_W-1:0]      pwdata,
	output logic [rabs_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	output rabs_pkg::cfg_t                    cfg
);

	rabs_pkg::cfg_t   cfg_q;
	rabs_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = rabs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate_q16   <= rabs_pkg::LEARN_RATE_RESET;
			cfg_q.fg_threshold     <= rabs_pkg::FG_THRESHOLD_RESET;
			cfg_q.threshold_enable <= rabs_pkg::THRESHOLD_EN_RESET;
		end else if (wr_en) begin
			case (idx)
				rabs_pkg::REG_LEARN_RATE: begin
					cfg_q.learn_rate_q16 <= pwdata[15:0];
				end
				rabs_pkg::REG_FG_THRESHOLD: begin
					cfg_q.fg_threshold <= pwdata[7:0];
				end
				rabs_pkg::REG_THRESHOLD_EN: begin
					cfg_q.threshold_enable <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			rabs_pkg::REG_LEARN_RATE:   prdata = {16'd0, cfg_q.learn_rate_q16};
			rabs_pkg::REG_FG_THRESHOLD: prdata = {24'd0, cfg_q.fg_threshold};
			rabs_pkg::REG_THRESHOLD_EN: prdata = {31'd0, cfg_q.threshold_enable};
			default:                    prdata = '0;
		endcase
	end

endmodule
